@@ hdl/slcfp_pkg.sv @@
// Package: shared types, constants and codes for the frame parser.
package slcfp_pkg;

  localparam logic [7:0]  SYNC_BYTE   = 8'hda;
  localparam logic [16:0] POS_LIMIT   = 17'd65540;
  localparam logic [16:0] POS_CHKSUM  = 17'd9;
  localparam logic [16:0] POS_HDR_MIN = 17'd4;
  localparam logic [16:0] POS_IE_MIN  = 17'd10;
  localparam logic [16:0] LEN_OFFSET  = 17'd4;

  localparam logic [2:0] ROLE_SYNC    = 3'd0;
  localparam logic [2:0] ROLE_LENGTH  = 3'd1;
  localparam logic [2:0] ROLE_HEADER  = 3'd2;
  localparam logic [2:0] ROLE_CHKSUM  = 3'd3;
  localparam logic [2:0] ROLE_IE_HDR  = 3'd4;
  localparam logic [2:0] ROLE_IE_BODY = 3'd5;
  localparam logic [2:0] ROLE_IGNORED = 3'd6;

  localparam logic [2:0] STATUS_OK         = 3'd0;
  localparam logic [2:0] STATUS_TOO_SHORT  = 3'd1;
  localparam logic [2:0] STATUS_BAD_SYNC   = 3'd2;
  localparam logic [2:0] STATUS_LEN_BAD    = 3'd3;
  localparam logic [2:0] STATUS_CHKSUM     = 3'd4;
  localparam logic [2:0] STATUS_IE_CUT     = 3'd5;
  localparam logic [2:0] STATUS_IE_OVERRUN = 3'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } item_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [2:0]  byte_role;
    logic        frame_done;
    logic [2:0]  status;
    logic [7:0]  cookie_out;
    logic [7:0]  unit_out;
    logic [15:0] service_out;
    logic [7:0]  message_out;
  } result_t;

endpackage

@@ hdl/slcfp_if.sv @@
// Interfaces: input byte channel and result channel.
interface slcfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface slcfp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_out;
  logic [2:0]  byte_role;
  logic        frame_done;
  logic [2:0]  status;
  logic [7:0]  cookie_out;
  logic [7:0]  unit_out;
  logic [15:0] service_out;
  logic [7:0]  message_out;

  modport source (output valid, output byte_out, output byte_role, output frame_done,
                  output status, output cookie_out, output unit_out,
                  output service_out, output message_out, input ready);
  modport sink   (input valid, input byte_out, input byte_role, input frame_done,
                  input status, input cookie_out, input unit_out,
                  input service_out, input message_out, output ready);
endinterface

@@ hdl/slcfp_parse.sv @@
// Parser core: frame state, per-byte decode and result register.
module slcfp_parse
  import slcfp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  item_t   item,
  output logic    item_ready,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  typedef enum logic [1:0] {
    IE_TYPE,
    IE_SIZE_HI,
    IE_SIZE_LO,
    IE_BODY
  } ie_phase_t;

  logic [16:0] byte_position, byte_position_next;
  logic [15:0] declared_length, declared_length_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  received_checksum, received_checksum_next;
  logic        sync_bad, sync_bad_next;
  ie_phase_t   ie_phase, ie_phase_next;
  logic [7:0]  ie_size_high, ie_size_high_next;
  logic [15:0] ie_bytes_left, ie_bytes_left_next;
  logic [7:0]  captured_cookie, captured_cookie_next;
  logic [7:0]  captured_unit, captured_unit_next;
  logic [15:0] captured_service, captured_service_next;
  logic [7:0]  captured_message, captured_message_next;
  result_t     res_next;
  logic        fire;

  assign item_ready = !res_valid || res_ready;
  assign fire       = item_valid && item_ready;

  always_comb begin
    logic [7:0]  b;
    logic [2:0]  role;
    logic [16:0] n;
    logic [15:0] ie_len;
    logic [15:0] left_dec;
    logic [2:0]  stat;

    b                      = item.data_byte;
    role                   = ROLE_IGNORED;
    n                      = byte_position + 17'd1;
    ie_len                 = {ie_size_high, b};
    left_dec               = ie_bytes_left;
    stat                   = STATUS_OK;
    declared_length_next   = declared_length;
    running_sum_next       = running_sum;
    received_checksum_next = received_checksum;
    sync_bad_next          = sync_bad;
    ie_phase_next          = ie_phase;
    ie_size_high_next      = ie_size_high;
    ie_bytes_left_next     = ie_bytes_left;
    captured_cookie_next   = captured_cookie;
    captured_unit_next     = captured_unit;
    captured_service_next  = captured_service;
    captured_message_next  = captured_message;

    if (byte_position < 17'd2) begin
      role = ROLE_SYNC;
      if (b != SYNC_BYTE) sync_bad_next = 1'b1;
    end else if (byte_position < POS_HDR_MIN) begin
      role                 = ROLE_LENGTH;
      declared_length_next = {declared_length[7:0], b};
      running_sum_next     = running_sum + b;
    end else if (byte_position < POS_CHKSUM) begin
      role             = ROLE_HEADER;
      running_sum_next = running_sum + b;
      case (byte_position[2:0])
        3'd4:    captured_cookie_next = b;
        3'd5:    captured_unit_next = b;
        3'd6:    captured_service_next = {b, captured_service[7:0]};
        3'd7:    captured_service_next = {captured_service[15:8], b};
        default: captured_message_next = b;
      endcase
    end else if (byte_position == POS_CHKSUM) begin
      role                   = ROLE_CHKSUM;
      received_checksum_next = b;
    end else if (byte_position < POS_LIMIT) begin
      running_sum_next = running_sum + b;
      unique case (ie_phase)
        IE_TYPE: begin
          role          = ROLE_IE_HDR;
          ie_phase_next = IE_SIZE_HI;
        end
        IE_SIZE_HI: begin
          role              = ROLE_IE_HDR;
          ie_size_high_next = b;
          ie_phase_next     = IE_SIZE_LO;
        end
        IE_SIZE_LO: begin
          role = ROLE_IE_HDR;
          if (ie_len == 16'd0) begin
            ie_phase_next = IE_TYPE;
          end else begin
            ie_bytes_left_next = ie_len;
            ie_phase_next      = IE_BODY;
          end
        end
        default: begin
          role = ROLE_IE_BODY;
          if (ie_bytes_left != 16'd0) left_dec = ie_bytes_left - 16'd1;
          ie_bytes_left_next = left_dec;
          if (left_dec == 16'd0) ie_phase_next = IE_TYPE;
        end
      endcase
    end

    byte_position_next = (byte_position < POS_LIMIT) ? n : POS_LIMIT;

    if (n < POS_HDR_MIN)
      stat = STATUS_TOO_SHORT;
    else if (sync_bad_next)
      stat = STATUS_BAD_SYNC;
    else if (({1'b0, declared_length_next} + LEN_OFFSET) != n)
      stat = STATUS_LEN_BAD;
    else if (n < POS_IE_MIN)
      stat = STATUS_TOO_SHORT;
    else if (running_sum_next != received_checksum_next)
      stat = STATUS_CHKSUM;
    else if (ie_phase_next == IE_SIZE_HI || ie_phase_next == IE_SIZE_LO)
      stat = STATUS_IE_CUT;
    else if (ie_phase_next == IE_BODY)
      stat = STATUS_IE_OVERRUN;

    res_next            = '0;
    res_next.byte_out   = b;
    res_next.byte_role  = role;
    if (item.end_of_buffer) begin
      res_next.frame_done  = 1'b1;
      res_next.status      = stat;
      res_next.cookie_out  = captured_cookie_next;
      res_next.unit_out    = captured_unit_next;
      res_next.service_out = captured_service_next;
      res_next.message_out = captured_message_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid         <= 1'b0;
      byte_position     <= '0;
      declared_length   <= '0;
      running_sum       <= '0;
      received_checksum <= '0;
      sync_bad          <= 1'b0;
      ie_phase          <= IE_TYPE;
      ie_size_high      <= '0;
      ie_bytes_left     <= '0;
      captured_cookie   <= '0;
      captured_unit     <= '0;
      captured_service  <= '0;
      captured_message  <= '0;
    end else if (fire) begin
      res_valid <= 1'b1;
      res       <= res_next;
      if (item.end_of_buffer) begin
        byte_position     <= '0;
        declared_length   <= '0;
        running_sum       <= '0;
        received_checksum <= '0;
        sync_bad          <= 1'b0;
        ie_phase          <= IE_TYPE;
        ie_size_high      <= '0;
        ie_bytes_left     <= '0;
        captured_cookie   <= '0;
        captured_unit     <= '0;
        captured_service  <= '0;
        captured_message  <= '0;
      end else begin
        byte_position     <= byte_position_next;
        declared_length   <= declared_length_next;
        running_sum       <= running_sum_next;
        received_checksum <= received_checksum_next;
        sync_bad          <= sync_bad_next;
        ie_phase          <= ie_phase_next;
        ie_size_high      <= ie_size_high_next;
        ie_bytes_left     <= ie_bytes_left_next;
        captured_cookie   <= captured_cookie_next;
        captured_unit     <= captured_unit_next;
        captured_service  <= captured_service_next;
        captured_message  <= captured_message_next;
      end
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

`ifndef SYNTH
  a_pos_sat: assert property (@(posedge clk) disable iff (rst)
    byte_position <= POS_LIMIT)
    else $error("byte position beyond limit");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (fire && item.end_of_buffer) |=> (byte_position == 17'd0 && ie_phase == IE_TYPE))
    else $error("state not cleared after last byte");

  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.frame_done) |->
      (res.status == STATUS_OK && res.cookie_out == 8'd0 && res.service_out == 16'd0))
    else $error("header fields shown before last byte");

  a_ok_role: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.frame_done && res.status == STATUS_OK) |->
      (res.byte_role == ROLE_IE_HDR || res.byte_role == ROLE_IE_BODY
       || res.byte_role == ROLE_CHKSUM))
    else $error("good frame ended on unexpected byte role");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("stalled result changed");
`endif

endmodule

@@ hdl/sync_length_checksum_frame_parser_top.sv @@
// Top level: framed message parser with sync, length and 8-bit checksum checks.
//
//   channel | dir | payload                                         | handshake
//   in_ch   | in  | data_byte, end_of_buffer                        | valid/ready
//   out_ch  | out | byte_out, byte_role, frame_done, status,         | valid/ready
//           |     | cookie_out, unit_out, service_out, message_out   |
//
// One byte per cycle sustained while out_ch.ready stays high; a byte's result passes
// through the input register, then is decoded into the result register, where it
// is held until out_ch takes it.
// The per-byte decode, the 8-bit sum and the frame-status compare set the cycle.
// Synchronous reset clears the frame state and both valid flags.
// A stalled result holds; the input register still takes a byte while it is empty.
module sync_length_checksum_frame_parser_top
  import slcfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  slcfp_in_if.sink    in_ch,
  slcfp_out_if.source out_ch
);

  logic    in_valid;
  item_t   in_item;
  logic    item_ready;
  logic    res_valid;
  result_t res;

  assign in_ch.ready = !in_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_valid                <= 1'b1;
      in_item.data_byte       <= in_ch.data_byte;
      in_item.end_of_buffer   <= in_ch.end_of_buffer;
    end else if (item_ready) begin
      in_valid <= 1'b0;
    end
  end

  slcfp_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .item_valid (in_valid),
    .item       (in_item),
    .item_ready (item_ready),
    .res_valid  (res_valid),
    .res_ready  (out_ch.ready),
    .res        (res)
  );

  assign out_ch.valid       = res_valid;
  assign out_ch.byte_out    = res.byte_out;
  assign out_ch.byte_role   = res.byte_role;
  assign out_ch.frame_done  = res.frame_done;
  assign out_ch.status      = res.status;
  assign out_ch.cookie_out  = res.cookie_out;
  assign out_ch.unit_out    = res.unit_out;
  assign out_ch.service_out = res.service_out;
  assign out_ch.message_out = res.message_out;

endmodule
